@@ hw/rtl/ber_tlv_stream_decoder_assert.svh @@
// Assertion macros shared by the checker.
`ifndef BER_TLV_STREAM_DECODER_ASSERT_SVH
`define BER_TLV_STREAM_DECODER_ASSERT_SVH

// same-cycle implication
`define BTLV_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication
`define BTLV_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ hw/rtl/btlv_pkg.sv @@
`timescale 1ns / 1ps

package btlv_pkg;

  localparam logic [2:0] KIND_HEADER = 3'd0;
  localparam logic [2:0] KIND_BYTE   = 3'd1;
  localparam logic [2:0] KIND_SCALAR = 3'd2;
  localparam logic [2:0] KIND_END    = 3'd3;
  localparam logic [2:0] KIND_ERROR  = 3'd4;

  localparam logic [4:0] TAG_BOOLEAN   = 5'd1;
  localparam logic [4:0] TAG_INTEGER   = 5'd2;
  localparam logic [4:0] TAG_OID       = 5'd6;
  localparam logic [4:0] TAG_SEQUENCE  = 5'd16;
  localparam logic [4:0] TAG_PRINTABLE = 5'd19;
  localparam logic [4:0] TAG_UTCTIME   = 5'd23;
  localparam logic [4:0] TAG_END       = 5'd0;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  tag_class;
    logic        constructed;
    logic [4:0]  tag_number;
    logic [31:0] word;
  } rec_t;

endpackage

@@ hw/rtl/btlv_front.sv @@
`timescale 1ns / 1ps

module btlv_front #(
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       data_byte,
  input  logic             restart,
  output logic             push,
  output btlv_pkg::rec_t   rec
);

  localparam int LBL_W = $clog2(MAX_LENGTH_BYTES + 1);

  localparam logic [2:0] PH_TAG     = 3'd0;
  localparam logic [2:0] PH_LEN     = 3'd1;
  localparam logic [2:0] PH_LONGLEN = 3'd2;
  localparam logic [2:0] PH_CONTENT = 3'd3;
  localparam logic [2:0] PH_ENDED   = 3'd4;

  logic [2:0]       phase, phase_next, ph;
  logic [1:0]       held_class, held_class_next;
  logic             held_constructed, held_constructed_next;
  logic [4:0]       held_tag, held_tag_next;
  logic [31:0]      remaining, remaining_next;
  logic [LBL_W-1:0] length_bytes_left, length_bytes_left_next;
  logic [31:0]      accumulator, accumulator_next;
  logic [1:0]       value_index, value_index_next;

  logic             fin;
  logic [31:0]      fin_len;
  logic             emit;
  logic [2:0]       emit_kind;
  logic [31:0]      emit_word;
  logic             done;
  logic [1:0]       idx;

  always_comb begin
    ph                     = restart ? PH_TAG : phase;
    phase_next             = ph;
    held_class_next        = held_class;
    held_constructed_next  = held_constructed;
    held_tag_next          = held_tag;
    remaining_next         = remaining;
    length_bytes_left_next = length_bytes_left;
    accumulator_next       = accumulator;
    value_index_next       = value_index;
    fin       = 1'b0;
    fin_len   = 32'd0;
    emit      = 1'b0;
    emit_kind = btlv_pkg::KIND_HEADER;
    emit_word = 32'd0;
    done      = 1'b0;
    idx       = value_index;
    case (ph)
      PH_ENDED: begin
      end
      PH_LEN: begin
        if (data_byte[7]) begin
          if (data_byte[6:0] == 7'd0) begin
            fin = 1'b1;
          end else if (data_byte[6:0] > 7'(MAX_LENGTH_BYTES)) begin
            emit       = 1'b1;
            emit_kind  = btlv_pkg::KIND_ERROR;
            phase_next = PH_ENDED;
          end else begin
            accumulator_next       = 32'd0;
            length_bytes_left_next = LBL_W'(data_byte[6:0]);
            phase_next             = PH_LONGLEN;
          end
        end else begin
          fin     = 1'b1;
          fin_len = {24'd0, data_byte};
        end
      end
      PH_LONGLEN: begin
        accumulator_next = {accumulator[23:0], data_byte};
        if (length_bytes_left != '0) begin
          length_bytes_left_next = length_bytes_left - LBL_W'(1);
        end
        if (length_bytes_left_next == '0) begin
          fin              = 1'b1;
          fin_len          = accumulator_next;
          accumulator_next = 32'd0;
        end
      end
      PH_CONTENT: begin
        if (remaining != 32'd0) begin
          remaining_next = remaining - 32'd1;
        end
        done = (remaining_next == 32'd0);
        if (value_index != 2'd3) begin
          value_index_next = value_index + 2'd1;
        end
        case (held_tag)
          btlv_pkg::TAG_BOOLEAN: begin
            if (idx == 2'd0) begin
              emit      = 1'b1;
              emit_kind = btlv_pkg::KIND_SCALAR;
              emit_word = {24'd0, data_byte};
            end
          end
          btlv_pkg::TAG_INTEGER: begin
            accumulator_next = {accumulator[23:0], data_byte};
            if (done) begin
              emit      = 1'b1;
              emit_kind = btlv_pkg::KIND_SCALAR;
              emit_word = accumulator_next;
            end
          end
          btlv_pkg::TAG_UTCTIME: begin
            if (idx == 2'd0) begin
              accumulator_next = {16'd0, data_byte, 8'd0};
            end else if (idx == 2'd1) begin
              accumulator_next = accumulator | {24'd0, data_byte};
            end
            if (idx == 2'd1 || (done && idx == 2'd0)) begin
              emit      = 1'b1;
              emit_kind = btlv_pkg::KIND_SCALAR;
              emit_word = accumulator_next;
            end
          end
          btlv_pkg::TAG_OID, btlv_pkg::TAG_PRINTABLE: begin
            emit      = 1'b1;
            emit_kind = btlv_pkg::KIND_BYTE;
            emit_word = {24'd0, data_byte};
          end
          default: begin
          end
        endcase
        if (done) begin
          phase_next = PH_TAG;
        end
      end
      default: begin
        held_class_next       = data_byte[7:6];
        held_constructed_next = data_byte[5];
        held_tag_next         = data_byte[4:0];
        if (data_byte[4:0] == btlv_pkg::TAG_END) begin
          emit       = 1'b1;
          emit_kind  = btlv_pkg::KIND_END;
          phase_next = PH_ENDED;
        end else begin
          phase_next = PH_LEN;
        end
      end
    endcase
    if (fin) begin
      emit      = 1'b1;
      emit_kind = btlv_pkg::KIND_HEADER;
      emit_word = fin_len;
      if (held_constructed || held_tag == btlv_pkg::TAG_SEQUENCE || fin_len == 32'd0) begin
        phase_next = PH_TAG;
      end else begin
        remaining_next   = fin_len;
        accumulator_next = 32'd0;
        value_index_next = 2'd0;
        phase_next       = PH_CONTENT;
      end
    end
  end

  assign push            = accept && emit;
  assign rec.kind        = emit_kind;
  assign rec.tag_class   = held_class_next;
  assign rec.constructed = held_constructed_next;
  assign rec.tag_number  = held_tag_next;
  assign rec.word        = emit_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_TAG;
      held_class        <= '0;
      held_constructed  <= 1'b0;
      held_tag          <= '0;
      remaining         <= '0;
      length_bytes_left <= '0;
      accumulator       <= '0;
      value_index       <= '0;
    end else if (accept) begin
      phase             <= phase_next;
      held_class        <= held_class_next;
      held_constructed  <= held_constructed_next;
      held_tag          <= held_tag_next;
      remaining         <= remaining_next;
      length_bytes_left <= length_bytes_left_next;
      accumulator       <= accumulator_next;
      value_index       <= value_index_next;
    end
  end

endmodule

@@ hw/rtl/btlv_queue.sv @@
`timescale 1ns / 1ps

module btlv_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  btlv_pkg::rec_t push_rec,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output btlv_pkg::rec_t head
);

  btlv_pkg::rec_t                    entries [btlv_pkg::QUEUE_DEPTH];
  logic [btlv_pkg::QPTR_W-1:0]       wr_ptr;
  logic [btlv_pkg::QPTR_W-1:0]       rd_ptr;
  logic [btlv_pkg::QCNT_W-1:0]       count;

  assign full  = (count == btlv_pkg::QCNT_W'(btlv_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == btlv_pkg::QPTR_W'(btlv_pkg::QUEUE_DEPTH - 1)) ? '0
                  : wr_ptr + btlv_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == btlv_pkg::QPTR_W'(btlv_pkg::QUEUE_DEPTH - 1)) ? '0
                  : rd_ptr + btlv_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + btlv_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - btlv_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

@@ hw/rtl/btlv_back.sv @@
`timescale 1ns / 1ps

module btlv_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           empty,
  input  btlv_pkg::rec_t head,
  output logic           pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [79:0]    m_tdata,
  output logic [2:0]     m_tuser,
  output logic           m_tlast
);

  logic [79:0] data_next;
  logic [31:0] length_f;
  logic [31:0] value_f;
  logic [7:0]  byte_f;

  assign pop = !empty && (!m_tvalid || m_tready);

  // unpack the shared word by kind
  always_comb begin
    length_f = 32'd0;
    value_f  = 32'd0;
    byte_f   = 8'd0;
    case (head.kind)
      btlv_pkg::KIND_HEADER: length_f = head.word;
      btlv_pkg::KIND_SCALAR: value_f  = head.word;
      btlv_pkg::KIND_BYTE:   byte_f   = head.word[7:0];
      default: begin
      end
    endcase
    data_next = {byte_f, value_f, length_f, head.tag_number, head.constructed, head.tag_class};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata <= data_next;
      m_tuser <= head.kind;
    end
  end

  assign m_tlast = 1'b1;

endmodule

@@ hw/rtl/ber_tlv_stream_decoder.sv @@
`timescale 1ns / 1ps
// Channel | Dir | Handshake          | Payload
// s       | in  | s_tvalid/s_tready  | tdata: data_byte; tuser: restart
// m       | out | m_tvalid/m_tready  | tdata: result fields; tuser: kind; tlast: last
//
// One byte per cycle while s_tready is high; a result for an accepted byte is written to the queue
// at the accepting edge and then passes through the output register before it is valid on m.
// The parser state is updated once per accepted byte in the front, which sets the one-byte rate.
// Synchronous reset clears parser state, the queue and the output valid.
// s_tready drops only when the 2-entry queue is full under a stalled m side.

module ber_tlv_stream_decoder #(
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_tuser,   // [0] restart
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // [1:0] tag_class, [2] constructed, [7:3] tag_number,
                                 // [39:8] length, [71:40] value, [79:72] content_byte
  output logic [2:0]  m_tuser,   // [2:0] kind
  output logic        m_tlast    // last
);

  logic           accept;
  logic           push;
  logic           pop;
  logic           full;
  logic           empty;
  btlv_pkg::rec_t rec;
  btlv_pkg::rec_t head;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  btlv_front #(
    .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (s_tdata),
    .restart   (s_tuser[0]),
    .push      (push),
    .rec       (rec)
  );

  btlv_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (rec),
    .pop      (pop),
    .full     (full),
    .empty    (empty),
    .head     (head)
  );

  btlv_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

@@ hw/rtl/btlv_checker.sv @@
`timescale 1ns / 1ps
`include "ber_tlv_stream_decoder_assert.svh"

module btlv_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic [0:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  logic is_header;
  logic is_byte;

  assign is_header = (m_tuser == btlv_pkg::KIND_HEADER);
  assign is_byte   = (m_tuser == btlv_pkg::KIND_BYTE);

  `BTLV_ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
  `BTLV_ASSERT_NXT(a_reset_quiet, clk, 1'b0, rst, !m_tvalid)
  `BTLV_ASSERT_IMP(a_one_per_byte, clk, rst, m_tvalid, m_tlast)
  `BTLV_ASSERT_IMP(a_len_only_header, clk, rst, m_tvalid && !is_header, m_tdata[39:8] == 32'd0)
  `BTLV_ASSERT_IMP(a_byte_only_kind, clk, rst, m_tvalid && !is_byte, m_tdata[79:72] == 8'd0)

endmodule

bind ber_tlv_stream_decoder btlv_checker u_btlv_checker (.*);

@@ sim/ber_tlv_stream_decoder_checker.sv @@
`timescale 1ns / 1ps

module ber_tlv_stream_decoder_checker #(
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_tuser,   // [0] restart
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [79:0] m_tdata,   // [1:0] tag_class, [2] constructed, [7:3] tag_number,
                                 // [39:8] length, [71:40] value, [79:72] content_byte
  input  logic [2:0]  m_tuser,   // [2:0] kind
  input  logic        m_tlast,
  output int          fail_count,
  output int          pending
);

  import btlv_pkg::*;

  typedef enum logic [2:0] {
    AT_TAG,
    AT_LENGTH,
    AT_LONG_LENGTH,
    AT_CONTENT,
    AT_ENDED
  } parse_phase_e;

  typedef struct {
    logic [2:0]  kind;
    logic [1:0]  tag_class;
    logic        constructed;
    logic [4:0]  tag_number;
    logic [31:0] length;
    logic [31:0] value;
    logic [7:0]  content_byte;
    logic        last;
  } tlv_result_t;

  tlv_result_t  predicted[$];

  parse_phase_e phase;
  logic [1:0]   held_class;
  logic         held_constructed;
  logic [4:0]   held_tag;
  logic [31:0]  remaining;
  logic [2:0]   len_bytes_left;
  logic [31:0]  acc;
  logic [1:0]   value_index;

  function automatic void clear_parser();
    phase            = AT_TAG;
    held_class       = '0;
    held_constructed = 1'b0;
    held_tag         = '0;
    remaining        = '0;
    len_bytes_left   = '0;
    acc              = '0;
    value_index      = '0;
  endfunction

  function automatic void push_result(input logic [2:0] kind, input logic [31:0] len,
                                      input logic [31:0] val, input logic [7:0] cb);
    tlv_result_t r;
    r.kind         = kind;
    r.tag_class    = held_class;
    r.constructed  = held_constructed;
    r.tag_number   = held_tag;
    r.length       = len;
    r.value        = val;
    r.content_byte = cb;
    r.last         = 1'b1;
    predicted.push_back(r);
  endfunction

  function automatic void close_header(input logic [31:0] len);
    push_result(KIND_HEADER, len, '0, '0);
    if (held_constructed || held_tag == TAG_SEQUENCE || len == 0) begin
      phase = AT_TAG;
    end else begin
      remaining   = len;
      acc         = '0;
      value_index = '0;
      phase       = AT_CONTENT;
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic restart);
    logic [6:0]  count;
    logic [31:0] len;
    logic        at_end;
    logic [1:0]  idx;
    if (restart) clear_parser();
    case (phase)
      AT_ENDED: ;
      AT_LENGTH: begin
        if (b[7]) begin
          count = b[6:0];
          if (count == 0) begin
            close_header('0);
          end else if (count > MAX_LENGTH_BYTES) begin
            push_result(KIND_ERROR, '0, '0, '0);
            phase = AT_ENDED;
          end else begin
            acc            = '0;
            len_bytes_left = count[2:0];
            phase          = AT_LONG_LENGTH;
          end
        end else begin
          close_header({24'd0, b});
        end
      end
      AT_LONG_LENGTH: begin
        acc = {acc[23:0], b};
        if (len_bytes_left != 0) len_bytes_left--;
        if (len_bytes_left == 0) begin
          len = acc;
          acc = '0;
          close_header(len);
        end
      end
      AT_CONTENT: begin
        if (remaining != 0) remaining--;
        at_end = (remaining == 0);
        idx = value_index;
        if (value_index < 3) value_index++;
        case (held_tag)
          TAG_BOOLEAN: begin
            if (idx == 0) push_result(KIND_SCALAR, '0, {24'd0, b}, '0);
          end
          TAG_INTEGER: begin
            acc = {acc[23:0], b};
            if (at_end) push_result(KIND_SCALAR, '0, acc, '0);
          end
          TAG_UTCTIME: begin
            if (idx == 0) acc = {16'd0, b, 8'd0};
            else if (idx == 1) acc = acc | {24'd0, b};
            if (idx == 1 || (at_end && idx == 0)) push_result(KIND_SCALAR, '0, acc, '0);
          end
          TAG_OID, TAG_PRINTABLE: begin
            push_result(KIND_BYTE, '0, '0, b);
          end
          default: ;
        endcase
        if (at_end) phase = AT_TAG;
      end
      default: begin
        held_class       = b[7:6];
        held_constructed = b[5];
        held_tag         = b[4:0];
        if (held_tag == TAG_END) begin
          push_result(KIND_END, '0, '0, '0);
          phase = AT_ENDED;
        end else begin
          phase = AT_LENGTH;
        end
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    tlv_result_t want;
    if (rst) begin
      clear_parser();
      predicted.delete();
    end else begin
      if (s_tvalid && s_tready) decode_byte(s_tdata, s_tuser[0]);
      if (m_tvalid && m_tready) begin
        if (predicted.size() == 0) begin
          $error("kind: expected no word, got 0x%0h", m_tuser);
          fail_count++;
        end else begin
          want = predicted.pop_front();
          check_field("kind", want.kind, m_tuser);
          check_field("tag_class", want.tag_class, m_tdata[1:0]);
          check_field("constructed", want.constructed, m_tdata[2]);
          check_field("tag_number", want.tag_number, m_tdata[7:3]);
          check_field("length", want.length, m_tdata[39:8]);
          check_field("value", want.value, m_tdata[71:40]);
          check_field("content_byte", want.content_byte, m_tdata[79:72]);
          check_field("last", want.last, m_tlast);
        end
      end
    end
    pending = predicted.size();
  end

endmodule

@@ sim/ber_tlv_stream_decoder_tb.sv @@
`timescale 1ns / 1ps

module ber_tlv_stream_decoder_tb;

  import btlv_pkg::*;

  localparam int         SHORT_FORM = -1;
  localparam logic [7:0] LONG_FORM  = 8'h80;

  typedef struct packed {
    logic       restart;
    logic [7:0] data;
  } stream_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;
  int          fail_count;
  int          pending;

  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           hold_len = 0;
  int           held = 0;
  logic         restart_next = 1'b0;
  stream_word_t stream_q[$];

  always #5 clk = ~clk;

  ber_tlv_stream_decoder uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  ber_tlv_stream_decoder_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // keep m_tready low once until held reaches hold_len, then stall at random
  always @(posedge clk) begin
    if (held < hold_len) begin
      m_tready <= 1'b0;
      held <= held + 1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic put(input logic [7:0] b);
    stream_q.push_back({restart_next, b});
    restart_next = 1'b0;
  endtask

  task automatic add_header(input logic [7:0] tag, input logic [31:0] len, input int form);
    put(tag);
    if (form == SHORT_FORM) begin
      put(len[7:0]);
    end else begin
      put(LONG_FORM | form[7:0]);
      for (int i = form - 1; i >= 0; i--) put(len[8*i +: 8]);
    end
  endtask

  task automatic add_random_item();
    int         pick;
    int         n;
    int         form;
    logic [4:0] number;
    logic [1:0] cls;
    pick = $urandom_range(99);
    cls = 2'($urandom_range(3));
    if (pick < 62) begin
      case ($urandom_range(5))
        0: number = TAG_BOOLEAN;
        1: number = TAG_INTEGER;
        2: number = TAG_OID;
        3: number = TAG_PRINTABLE;
        4: number = TAG_UTCTIME;
        default: number = 5'($urandom_range(1, 31));
      endcase
      n = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
      form = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : SHORT_FORM;
      if (n == 0 && $urandom_range(2) == 0) form = 0;
      add_header({cls, 1'b0, number}, n, form);
      repeat (n) put(8'($urandom_range(255)));
    end else if (pick < 77) begin
      if ($urandom_range(3) == 0) add_header({cls, 1'b0, TAG_SEQUENCE}, $urandom_range(127),
                                             SHORT_FORM);
      else add_header({cls, 1'b1, 5'($urandom_range(1, 31))}, $urandom(),
                      $urandom_range(1, 4));
    end else if (pick < 83) begin
      put({cls, 1'($urandom_range(1)), TAG_END});
      repeat ($urandom_range(3)) put(8'($urandom_range(255)));
      restart_next = 1'b1;
    end else if (pick < 88) begin
      put({cls, 1'($urandom_range(1)), 5'($urandom_range(1, 31))});
      put(8'($urandom_range(133, 255)));
      repeat ($urandom_range(2)) put(8'($urandom_range(255)));
      restart_next = 1'b1;
    end else if (pick < 94) begin
      put({cls, 1'b0, 5'($urandom_range(1, 31))});
      if ($urandom_range(1)) put(LONG_FORM | 8'($urandom_range(2, 4)));
      restart_next = 1'b1;
    end else begin
      restart_next = 1'($urandom_range(1));
      repeat ($urandom_range(1, 3)) put(8'($urandom_range(255)));
      restart_next = 1'b1;
    end
  endtask

  task automatic drive_stream();
    stream_word_t w;
    while (stream_q.size() != 0) begin
      w = stream_q.pop_front();
      if ($urandom_range(99) < send_idle_pct) begin
        s_tvalid <= 1'b0;
        do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= w.data;
      s_tuser  <= w.restart;
      do @(posedge clk); while (!s_tready);
    end
    s_tvalid <= 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_header({2'b00, 1'b0, TAG_BOOLEAN}, 2, SHORT_FORM);
    put(8'hFF);
    put(8'h00);
    add_header({2'b00, 1'b0, TAG_INTEGER}, 2, 1);
    put(8'h7F);
    put(8'hFF);
    add_header({2'b01, 1'b0, TAG_UTCTIME}, 1, SHORT_FORM);
    put(8'h0C);
    add_header({2'b10, 1'b0, TAG_PRINTABLE}, 0, 0);
    add_header({2'b11, 1'b1, TAG_OID}, 32'hFFFF_FFFF, 4);
    add_header({2'b00, 1'b0, 5'd5}, 1, SHORT_FORM);
    put(8'hAA);
    add_header({2'b00, 1'b0, TAG_SEQUENCE}, 3, SHORT_FORM);
    put({2'b11, 1'b0, TAG_END});
    put(8'h55);
    restart_next = 1'b1;
    add_header({2'b00, 1'b0, TAG_OID}, 1, SHORT_FORM);
    put(8'h31);
    put({2'b00, 1'b0, TAG_INTEGER});
    put(LONG_FORM | 8'h7F);
    restart_next = 1'b1;
    drive_stream();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          hold_len <= 300;
        end
        1: begin
          send_idle_pct = 47;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 47;
        end
        default: begin
          send_idle_pct = 33;
          recv_stall_pct = 33;
        end
      endcase
      while (stream_q.size() < 255) add_random_item();
      drive_stream();
    end

    repeat (10) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/btlv_pkg.sv
hw/rtl/btlv_front.sv
hw/rtl/btlv_queue.sv
hw/rtl/btlv_back.sv
hw/rtl/ber_tlv_stream_decoder.sv
hw/rtl/btlv_checker.sv
sim/ber_tlv_stream_decoder_checker.sv
sim/ber_tlv_stream_decoder_tb.sv
